// ===== design/wft_pkg.sv =====
// Shared types and constants of the word frequency table.
package wft_pkg;
    localparam int ENTRIES      = 64;
    localparam int MAX_WORD_LEN = 32;
    localparam int IDX_W  = 6;
    localparam int POS_W  = 5;
    localparam int LEN_W  = 6;
    localparam int USED_W = 7;
    localparam int CNT_W  = 16;

    localparam logic [7:0]       CHAR_A    = 8'h61;
    localparam logic [7:0]       CHAR_Z    = 8'h7a;
    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hffff;

    typedef enum logic [1:0] {
        OP_CHAR      = 2'd0,
        OP_READ_CNT  = 2'd1,
        OP_READ_CHAR = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_NEW       = 3'd0,
        ST_COUNTED   = 3'd1,
        ST_NOT_LOWER = 3'd2,
        ST_FULL      = 3'd3,
        ST_TOO_LONG  = 3'd4,
        ST_READ_OK   = 3'd5,
        ST_BAD_INDEX = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        EM_NOT_LOWER,
        EM_TOO_LONG,
        EM_COUNTED,
        EM_FULL,
        EM_NEW,
        EM_READ,
        EM_BAD
    } t_emit;

    typedef struct packed {
        logic  char_wr;
        logic  latch_req;
        logic  rd_idx;
        logic  rd_k;
        logic  k_clear;
        logic  k_inc;
        logic  hit_write;
        logic  append;
        logic  word_clear;
        logic  emit;
        t_emit emit_kind;
    } t_cmd;

    typedef struct packed {
        logic out_valid;
        logic idx_bad;
        logic all_lower;
        logic overflow;
        logic used_zero;
        logic match;
        logic k_last;
        logic full;
    } t_stat;
endpackage

// ===== design/wft_ctrl.sv =====
// Sequencer for character intake, table search and entry reads.
module wft_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_opcode,
    input  logic          i_word_end,
    input  wft_pkg::t_stat i_stat,
    output logic          o_ready,
    output wft_pkg::t_cmd  o_cmd
);
    import wft_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDWAIT,
        S_CHECK,
        S_FETCH,
        S_CMP
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE) && !i_stat.out_valid;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.emit_kind = EM_BAD;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_op'(i_opcode)) inside
                        OP_CHAR: begin
                            o_cmd.char_wr = 1'b1;
                            if (i_word_end) n_state = S_CHECK;
                        end
                        OP_READ_CNT, OP_READ_CHAR: begin
                            if (i_stat.idx_bad) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.emit_kind = EM_BAD;
                            end else begin
                                o_cmd.latch_req = 1'b1;
                                o_cmd.rd_idx    = 1'b1;
                                n_state = S_RDWAIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RDWAIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.emit_kind = EM_READ;
                n_state = S_IDLE;
            end
            S_CHECK: begin
                if (!i_stat.all_lower) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_kind = EM_NOT_LOWER;
                    o_cmd.word_clear = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.overflow) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_kind = EM_TOO_LONG;
                    o_cmd.word_clear = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.used_zero) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_kind = EM_NEW;
                    o_cmd.append = 1'b1;
                    o_cmd.word_clear = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.k_clear = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.rd_k = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_stat.match) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_kind = EM_COUNTED;
                    o_cmd.hit_write = 1'b1;
                    o_cmd.word_clear = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.k_last) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.word_clear = 1'b1;
                    if (i_stat.full) begin
                        o_cmd.emit_kind = EM_FULL;
                    end else begin
                        o_cmd.emit_kind = EM_NEW;
                        o_cmd.append = 1'b1;
                    end
                    n_state = S_IDLE;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_FETCH;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== design/wft_datapath.sv =====
// Word buffer, entry memory, search compare and result register.
module wft_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wft_pkg::t_cmd   i_cmd,
    input  logic [1:0]     i_opcode,
    input  logic [7:0]     i_char_code,
    input  logic [5:0]     i_entry_index,
    input  logic [4:0]     i_char_position,
    input  logic           i_out_ready,
    output wft_pkg::t_stat  o_stat,
    output logic           o_valid,
    output logic [2:0]     o_status,
    output logic [5:0]     o_entry_slot,
    output logic [15:0]    o_count,
    output logic [5:0]     o_word_length,
    output logic [7:0]     o_char_out,
    output logic [6:0]     o_entries_used
);
    import wft_pkg::*;

    typedef struct packed {
        logic [CNT_W-1:0]                 count;
        logic [LEN_W-1:0]                 len;
        logic [MAX_WORD_LEN-1:0][7:0]     chars;
    } t_row;

    // one row per entry: count, length and all characters
    t_row r_mem [ENTRIES];
    t_row r_rd;

    logic [7:0]        r_word [MAX_WORD_LEN];
    logic [LEN_W-1:0]  r_fill;
    logic              r_all_lower;
    logic              r_ovf;
    logic [USED_W-1:0] r_used, n_used;
    logic [IDX_W-1:0]  r_k;
    logic [IDX_W-1:0]  r_idx;
    logic [POS_W-1:0]  r_pos;
    logic              r_rd_char;

    logic              r_out_valid;
    t_status           r_status;
    logic [IDX_W-1:0]  r_slot;
    logic [CNT_W-1:0]  r_count;
    logic [LEN_W-1:0]  r_len;
    logic [7:0]        r_char;
    logic [USED_W-1:0] r_used_out;

    logic [MAX_WORD_LEN-1:0][7:0] word_vec;
    logic              chars_eq;
    logic [CNT_W-1:0]  sat_count;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_row              wr_row;
    logic              is_lower;

    always_comb begin
        chars_eq = 1'b1;
        for (int i = 0; i < MAX_WORD_LEN; i++) begin
            word_vec[i] = r_word[i];
            if ((LEN_W'(i) < r_fill) && (r_rd.chars[i] != r_word[i])) chars_eq = 1'b0;
        end
    end

    assign is_lower  = (i_char_code >= CHAR_A) && (i_char_code <= CHAR_Z);
    assign sat_count = (r_rd.count == COUNT_MAX) ? r_rd.count : r_rd.count + 16'd1;
    assign n_used    = i_cmd.append ? r_used + USED_W'(1) : r_used;

    assign o_stat.out_valid = r_out_valid;
    assign o_stat.idx_bad   = ({1'b0, i_entry_index} >= r_used);
    assign o_stat.all_lower = r_all_lower;
    assign o_stat.overflow  = r_ovf;
    assign o_stat.used_zero = (r_used == '0);
    assign o_stat.match     = (r_rd.len == r_fill) && chars_eq;
    assign o_stat.k_last    = ({1'b0, r_k} + USED_W'(1)) >= r_used;
    assign o_stat.full      = (r_used >= USED_W'(ENTRIES));

    always_comb begin
        wr_en   = i_cmd.hit_write || i_cmd.append;
        wr_addr = i_cmd.hit_write ? r_k : r_used[IDX_W-1:0];
        if (i_cmd.hit_write) begin
            wr_row = '{count: sat_count, len: r_rd.len, chars: r_rd.chars};
        end else begin
            wr_row = '{count: CNT_W'(1), len: r_fill, chars: word_vec};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_row;
        if (i_cmd.rd_idx) begin
            r_rd <= r_mem[i_entry_index];
        end else if (i_cmd.rd_k) begin
            r_rd <= r_mem[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_WORD_LEN; i++) begin
            if (i_cmd.char_wr && (r_fill == LEN_W'(i))) r_word[i] <= i_char_code;
        end
        if (i_cmd.latch_req) begin
            r_idx     <= i_entry_index;
            r_pos     <= i_char_position;
            r_rd_char <= (t_op'(i_opcode) == OP_READ_CHAR);
        end
        if (i_cmd.k_clear) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + IDX_W'(1);
        end
        if (i_cmd.emit) begin
            r_slot  <= '0;
            r_count <= '0;
            r_len   <= r_fill;
            r_char  <= '0;
            case (i_cmd.emit_kind)
                EM_NOT_LOWER: r_status <= ST_NOT_LOWER;
                EM_TOO_LONG:  r_status <= ST_TOO_LONG;
                EM_FULL:      r_status <= ST_FULL;
                EM_COUNTED: begin
                    r_status <= ST_COUNTED;
                    r_slot   <= r_k;
                    r_count  <= sat_count;
                    r_len    <= r_rd.len;
                end
                EM_NEW: begin
                    r_status <= ST_NEW;
                    r_slot   <= r_used[IDX_W-1:0];
                    r_count  <= CNT_W'(1);
                end
                EM_READ: begin
                    r_status <= ST_READ_OK;
                    r_slot   <= r_idx;
                    r_count  <= r_rd.count;
                    r_len    <= r_rd.len;
                    if (r_rd_char && ({1'b0, r_pos} < r_rd.len)) r_char <= r_rd.chars[r_pos];
                end
                default: begin
                    r_status <= ST_BAD_INDEX;
                    r_slot   <= i_entry_index;
                    r_len    <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_all_lower <= 1'b1;
            r_ovf       <= 1'b0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.word_clear) begin
                r_fill      <= '0;
                r_all_lower <= 1'b1;
                r_ovf       <= 1'b0;
            end else if (i_cmd.char_wr) begin
                if (!is_lower) r_all_lower <= 1'b0;
                if (r_fill < LEN_W'(MAX_WORD_LEN)) begin
                    r_fill <= r_fill + LEN_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            r_used <= n_used;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.emit) r_used_out <= n_used;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_entry_slot   = r_slot;
    assign o_count        = r_count;
    assign o_word_length  = r_len;
    assign o_char_out     = r_char;
    assign o_entries_used = r_used_out;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(ENTRIES)) else $error("entry count past table size");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LEN_W'(MAX_WORD_LEN)) else $error("word fill past limit");
    a_append_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |=> r_used == $past(r_used) + USED_W'(1))
        else $error("append did not advance entry count");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.emit && r_out_valid)) else $error("result overwritten");
endmodule

// ===== design/lowercase_word_frequency_table_core.sv =====
// Top level of the lowercase word frequency table.
// Words arrive one request per character; a character without word end leaves the sequencer idle.
// A finished word is first checked (lowercase, length, empty table), then each stored entry in
// turn is read as one row from the entry memory and compared against the buffered word, until
// a match or the last entry. Reads of an entry go through the registered memory read and a wait
// state, while a bad index is answered from the idle state without a memory read. One request is
// handled at a time and a new one is taken once the result register is empty.
module lowercase_word_frequency_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_char_code,
    input  logic        i_word_end,
    input  logic [5:0]  i_entry_index,
    input  logic [4:0]  i_char_position,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [5:0]  o_entry_slot,
    output logic [15:0] o_count,
    output logic [5:0]  o_word_length,
    output logic [7:0]  o_char_out,
    output logic [6:0]  o_entries_used
);
    import wft_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    wft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_opcode   (i_opcode),
        .i_word_end (i_word_end),
        .i_stat     (stat),
        .o_ready    (o_ready),
        .o_cmd      (cmd)
    );

    wft_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_opcode        (i_opcode),
        .i_char_code     (i_char_code),
        .i_entry_index   (i_entry_index),
        .i_char_position (i_char_position),
        .i_out_ready     (i_ready),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_entry_slot    (o_entry_slot),
        .o_count         (o_count),
        .o_word_length   (o_word_length),
        .o_char_out      (o_char_out),
        .o_entries_used  (o_entries_used)
    );
endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench of the lowercase word frequency table core.
module testbench;
    import wft_pkg::*;

    typedef struct {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [15:0] count;
        logic [5:0]  length;
        logic [7:0]  chr;
        logic [6:0]  used;
    } t_tally;

    // Word table mirror; computes the expected tally of each request that yields a result.
    class word_table_board;
        logic [7:0]  buf_chars [MAX_WORD_LEN];
        int          fill;
        bit          lower_ok;
        bit          overflow;
        logic [7:0]  chars [ENTRIES][MAX_WORD_LEN];
        int          lengths [ENTRIES];
        int          counts [ENTRIES];
        int          used;
        t_tally      pending [$];
        int          errors;

        function void clear();
            fill = 0;
            lower_ok = 1;
            overflow = 0;
            used = 0;
            errors = 0;
        endfunction

        function t_tally make(t_status st, int slot, int cnt, int len, int ch);
            t_tally t;
            t.status = st;
            t.slot   = slot[5:0];
            t.count  = cnt[15:0];
            t.length = len[5:0];
            t.chr    = ch[7:0];
            t.used   = used[6:0];
            return t;
        endfunction

        function void close_word();
            int k;
            bit same;
            if (!lower_ok) begin
                pending.push_back(make(ST_NOT_LOWER, 0, 0, fill, 0));
                return;
            end
            if (overflow) begin
                pending.push_back(make(ST_TOO_LONG, 0, 0, fill, 0));
                return;
            end
            for (k = 0; k < used; k++) begin
                same = (lengths[k] == fill);
                for (int j = 0; same && j < fill; j++)
                    if (chars[k][j] != buf_chars[j]) same = 0;
                if (same) begin
                    if (counts[k] < 65535) counts[k]++;
                    pending.push_back(make(ST_COUNTED, k, counts[k], lengths[k], 0));
                    return;
                end
            end
            if (used >= ENTRIES) begin
                pending.push_back(make(ST_FULL, 0, 0, fill, 0));
                return;
            end
            for (int j = 0; j < fill; j++) chars[used][j] = buf_chars[j];
            lengths[used] = fill;
            counts[used] = 1;
            used++;
            pending.push_back(make(ST_NEW, used - 1, 1, fill, 0));
        endfunction

        function void note_request(t_op op, logic [7:0] ch, logic last,
                                   logic [5:0] idx, logic [4:0] pos);
            int c;
            if (op == OP_CHAR) begin
                if (ch < CHAR_A || ch > CHAR_Z) lower_ok = 0;
                if (fill < MAX_WORD_LEN) buf_chars[fill++] = ch;
                else overflow = 1;
                if (last) begin
                    close_word();
                    fill = 0;
                    lower_ok = 1;
                    overflow = 0;
                end
            end else if (op == OP_READ_CNT || op == OP_READ_CHAR) begin
                if (idx >= used) begin
                    pending.push_back(make(ST_BAD_INDEX, idx, 0, 0, 0));
                end else begin
                    c = 0;
                    if (op == OP_READ_CHAR && pos < lengths[idx]) c = chars[idx][pos];
                    pending.push_back(make(ST_READ_OK, idx, counts[idx], lengths[idx], c));
                end
            end
        endfunction

        function void check_result(t_tally got);
            t_tally exp_t;
            if (pending.size() == 0) begin
                $error("unexpected result status=%0d", got.status);
                errors++;
                return;
            end
            exp_t = pending.pop_front();
            if (got.status !== exp_t.status) begin
                $error("status exp %0d got %0d", exp_t.status, got.status); errors++;
            end
            if (got.slot !== exp_t.slot) begin
                $error("entry_slot exp %0d got %0d", exp_t.slot, got.slot); errors++;
            end
            if (got.count !== exp_t.count) begin
                $error("count exp %0d got %0d", exp_t.count, got.count); errors++;
            end
            if (got.length !== exp_t.length) begin
                $error("word_length exp %0d got %0d", exp_t.length, got.length); errors++;
            end
            if (got.chr !== exp_t.chr) begin
                $error("char_out exp %0d got %0d", exp_t.chr, got.chr); errors++;
            end
            if (got.used !== exp_t.used) begin
                $error("entries_used exp %0d got %0d", exp_t.used, got.used); errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        req_valid = 0;
    logic        req_ready;
    logic [1:0]  req_op = 0;
    logic [7:0]  req_char = 0;
    logic        req_end = 0;
    logic [5:0]  req_idx = 0;
    logic [4:0]  req_pos = 0;
    logic        res_valid;
    logic        res_ready = 0;
    logic [2:0]  res_status;
    logic [5:0]  res_slot;
    logic [15:0] res_count;
    logic [5:0]  res_length;
    logic [7:0]  res_char;
    logic [6:0]  res_used;

    bit          calm = 0;
    bit          stim_done = 0;
    int          sent = 0;
    word_table_board board;

    lowercase_word_frequency_table_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(req_valid), .o_ready(req_ready),
        .i_opcode(req_op), .i_char_code(req_char), .i_word_end(req_end),
        .i_entry_index(req_idx), .i_char_position(req_pos),
        .o_valid(res_valid), .i_ready(res_ready),
        .o_status(res_status), .o_entry_slot(res_slot), .o_count(res_count),
        .o_word_length(res_length), .o_char_out(res_char), .o_entries_used(res_used)
    );

    always #10 clk = ~clk;

    // Result side: random stall bursts, checks on each accepted result.
    initial begin
        t_tally got;
        int gap;
        board = new();
        board.clear();
        @(posedge clk);
        forever begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 16);
                res_ready <= 0;
                repeat (gap) @(posedge clk);
            end
            res_ready <= 1;
            @(posedge clk);
            if (rst_n && res_valid && res_ready) begin
                got.status = res_status;
                got.slot   = res_slot;
                got.count  = res_count;
                got.length = res_length;
                got.chr    = res_char;
                got.used   = res_used;
                board.check_result(got);
            end
        end
    end

    task automatic send_request(t_op op, logic [7:0] ch, logic last,
                                logic [5:0] idx, logic [4:0] pos);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            req_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1;
        req_op    <= op;
        req_char  <= ch;
        req_end   <= last;
        req_idx   <= idx;
        req_pos   <= pos;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        board.note_request(op, ch, last, idx, pos);
        sent++;
    endtask

    task automatic send_word(int len, bit lower_only, int pool);
        logic [7:0] c;
        for (int i = 0; i < len; i++) begin
            if (lower_only) c = CHAR_A + 8'($urandom_range(0, pool - 1));
            else c = 8'($urandom_range(0, 255));
            send_request(OP_CHAR, c, i == len - 1, 6'($urandom), 5'($urandom));
        end
    endtask

    task automatic send_read(bit any_idx);
        int hi;
        hi = (board.used > 0 && !any_idx) ? board.used - 1 : 63;
        send_request($urandom_range(0, 1) ? OP_READ_CNT : OP_READ_CHAR,
                     8'($urandom), 1'($urandom), 6'($urandom_range(0, hi)), 5'($urandom));
    endtask

    initial begin
        int pick;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reads of empty table, extremes, bad bytes, lengths
        send_request(OP_READ_CNT, 8'h00, 0, 6'd0, 5'd0);
        send_request(OP_READ_CHAR, 8'hff, 1, 6'd63, 5'd31);
        send_request(OP_NONE, 8'hff, 1, 6'd63, 5'd31);
        send_request(OP_CHAR, CHAR_A, 1, 6'd0, 5'd0);
        send_request(OP_CHAR, CHAR_A, 1, 6'd0, 5'd0);
        send_request(OP_CHAR, CHAR_Z, 0, 6'd0, 5'd0);
        send_request(OP_READ_CHAR, 8'h00, 0, 6'd0, 5'd0);    // read mid-word
        send_request(OP_CHAR, CHAR_Z, 1, 6'd0, 5'd0);
        send_request(OP_CHAR, 8'h60, 0, 6'd0, 5'd0);
        send_request(OP_CHAR, 8'h7b, 1, 6'd0, 5'd0);
        send_request(OP_CHAR, 8'hff, 1, 6'd0, 5'd0);
        send_request(OP_CHAR, 8'h00, 1, 6'd0, 5'd0);
        send_request(OP_READ_CNT, 8'h00, 0, 6'd1, 5'd0);
        send_request(OP_READ_CHAR, 8'h00, 0, 6'd1, 5'd1);
        send_request(OP_READ_CHAR, 8'h00, 0, 6'd1, 5'd31);   // past the word
        send_request(OP_READ_CHAR, 8'h00, 0, 6'd2, 5'd0);
        send_word(32, 1, 26);
        send_word(33, 1, 26);
        send_word(40, 0, 0);
        send_request(OP_READ_CHAR, 8'h00, 0, 6'd2, 5'd31);

        // let the table drain before random traffic
        while (board.pending.size() != 0) @(posedge clk);

        while (sent < 1150) begin
            if (sent > 1000) calm = 1;
            pick = $urandom_range(0, 99);
            if (pick < 55) send_word($urandom_range(1, 4), 1, 3);      // repeats, counts
            else if (pick < 65) send_word($urandom_range(5, 32), 1, 26);
            else if (pick < 70) send_word($urandom_range(30, 36), 1, 26);
            else if (pick < 75) send_word($urandom_range(1, 8), 0, 0);
            else if (pick < 93) send_read(0);
            else if (pick < 98) send_read(1);
            else send_request(OP_NONE, 8'($urandom), 1'($urandom), 6'($urandom),
                              5'($urandom));
        end
        // fill the table and hit the full case
        while (board.used < ENTRIES) send_word(6, 1, 26);
        send_word(7, 1, 26);
        send_word(1, 1, 1);
        send_read(1);
        req_valid <= 0;
        stim_done = 1;
    end

    // saturating count: a long burst of one word is too costly, so it is left to counting
    initial begin
        int waited;
        wait (stim_done);
        waited = 0;
        while (board.pending.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("[lowercase_word_frequency_table_core] OK");
        else
            $display("[lowercase_word_frequency_table_core] ERROR");
        $finish;
    end

    initial begin
        #40000000;
        $display("[lowercase_word_frequency_table_core] ERROR");
        $finish;
    end
endmodule
